### rtl/core/lprr_pkg.sv
// Shared types, constants and helpers for the length-prefixed record ring.
// Used by lprr_store, lprr_ctrl and length_prefixed_record_ring.
// No dependencies.
package lprr_pkg;

	localparam int STORE_BYTES = 1024;
	localparam int HDR_BYTES   = 2;
	localparam int AW          = $clog2(STORE_BYTES);
	localparam int PW          = $clog2(STORE_BYTES + 1);
	localparam int LW          = 16;
	localparam int EW          = PW + LW + 1;

	typedef logic [AW-1:0] addr_t;
	typedef logic [PW-1:0] pos_t;
	typedef logic [LW-1:0] len_t;

	localparam len_t  WRAP_MARK     = 16'hFFFF;
	localparam pos_t  LAST_HDR_POS  = PW'(STORE_BYTES - HDR_BYTES);
	localparam addr_t MARK_LO_ADDR  = AW'(STORE_BYTES - 2);
	localparam addr_t MARK_HI_ADDR  = AW'(STORE_BYTES - 1);

	typedef enum logic [1:0] {
		OP_PUSH_START = 2'd0,
		OP_PUSH_BYTE  = 2'd1,
		OP_POP_BYTE   = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_SEQ   = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECIDE,
		S_MARK_LO,
		S_MARK_HI,
		S_HDR_LO,
		S_HDR_HI,
		S_RD_HHI,
		S_RD_HCHK,
		S_RD_DATA,
		S_RESP
	} state_t;

	typedef struct packed {
		logic       en;
		addr_t      addr;
		logic [7:0] data;
	} mem_wr_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
	} mem_rd_t;

	typedef struct packed {
		status_t    status;
		logic [7:0] data_out;
		len_t       popped_length;
		logic       last_byte;
	} res_t;

	// positions with fewer than two bytes left go back to the base
	function automatic pos_t settle(pos_t p);
		return (32'(p) + HDR_BYTES > STORE_BYTES) ? '0 : p;
	endfunction

endpackage

### rtl/core/length_prefixed_record_ring.sv
// Length-prefixed record ring: top level with byte store, sequencer and output register.
// Each word is answered with one result: a push_start writes the two header bytes, preceded
// by a wrap marker when one is needed; a pop at the start of a record reads the header first,
// skipping a wrap marker, and an empty record returns no data byte.
// One word at a time, paced by the single read and write port of the store.
// Asynchronous reset clears all pointers; the store itself is not swept.
module length_prefixed_record_ring (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // record_length[15:0], data_in[23:16]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // data_out[7:0], popped_length[23:8]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	output logic        m_axis_tlast
);
	import lprr_pkg::*;

	mem_wr_t    wr;
	mem_rd_t    rd;
	logic [7:0] rdata;
	logic       res_valid;
	logic       res_ready;
	res_t       res;
	res_t       out_q;
	logic       out_valid_q;

	lprr_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.rd     (rd),
		.rdata  (rdata)
	);

	lprr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_op     (s_axis_tuser),
		.in_len    (s_axis_tdata[15:0]),
		.in_din    (s_axis_tdata[23:16]),
		.wr        (wr),
		.rd        (rd),
		.rdata     (rdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.popped_length, out_q.data_out};
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last_byte;

endmodule

### rtl/core/lprr_store.sv
// Byte store of the record ring: one write port, one read port, registered read.
// Tracks the reset wrap marker in the last two bytes until they are overwritten.
// Depends on lprr_pkg.
module lprr_store (
	input  logic              clk,
	input  logic              arst_n,
	input  lprr_pkg::mem_wr_t wr,
	input  lprr_pkg::mem_rd_t rd,
	output logic [7:0]        rdata
);
	import lprr_pkg::*;

	logic [7:0] mem [STORE_BYTES];
	logic [1:0] mark_q;
	logic [7:0] rdata_s1;
	logic       rd_mark_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rdata_s1   <= mem[rd.addr];
			rd_mark_s1 <= (rd.addr == MARK_LO_ADDR && mark_q[0]) ||
				(rd.addr == MARK_HI_ADDR && mark_q[1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= 2'b11;
		end else if (wr.en) begin
			if (wr.addr == MARK_LO_ADDR) begin
				mark_q[0] <= 1'b0;
			end
			if (wr.addr == MARK_HI_ADDR) begin
				mark_q[1] <= 1'b0;
			end
		end
	end

	assign rdata = rd_mark_s1 ? 8'hFF : rdata_s1;

endmodule

### rtl/core/lprr_ctrl.sv
// Sequencer of the record ring: decodes a word, runs the header, marker and
// data accesses on the byte store and keeps the ring pointers.
// Depends on lprr_pkg.
module lprr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [1:0]        in_op,
	input  lprr_pkg::len_t    in_len,
	input  logic [7:0]        in_din,
	output lprr_pkg::mem_wr_t wr,
	output lprr_pkg::mem_rd_t rd,
	input  logic [7:0]        rdata,
	output logic              res_valid,
	input  logic              res_ready,
	output lprr_pkg::res_t    res
);
	import lprr_pkg::*;

	state_t     state_q, state_d;

	logic [1:0] in_op_q;
	len_t       in_len_q;
	logic [7:0] in_din_q;
	pos_t       dest_q;
	logic [7:0] hdr_lo_q;
	len_t       plen_q;
	res_t       res_q;

	pos_t       commit_q;
	pos_t       wcur_q;
	pos_t       roff_q;
	pos_t       rcur_q;
	logic       never_q;
	len_t       push_left_q;
	len_t       pop_left_q;
	logic       pop_open_q;

	logic [EW-1:0] t_e, b_e, len_e, end_e;
	logic          wrap, full, too_long, need_mark, empty;
	pos_t          dest;
	len_t          hdr;
	logic          push_busy;
	res_t          res_dec;

	always_comb begin
		t_e       = EW'(commit_q);
		b_e       = EW'(roff_q);
		len_e     = EW'(in_len_q);
		end_e     = t_e + len_e + EW'(HDR_BYTES);
		wrap      = end_e > EW'(STORE_BYTES);
		too_long  = (in_len_q == WRAP_MARK) || (len_e > EW'(STORE_BYTES - HDR_BYTES));
		if (commit_q < roff_q) begin
			full = end_e >= b_e;
		end else if (wrap) begin
			full = (len_e + EW'(HDR_BYTES)) >= b_e;
		end else begin
			full = (end_e + EW'(HDR_BYTES) > EW'(STORE_BYTES)) && (roff_q == '0);
		end
		need_mark = wrap && (t_e + EW'(HDR_BYTES) <= EW'(STORE_BYTES));
		dest      = wrap ? '0 : commit_q;
		empty     = never_q || (roff_q == commit_q);
		hdr       = {rdata, hdr_lo_q};
		push_busy = push_left_q != '0;
	end

	// result fields fixed at decode
	always_comb begin
		res_dec = '0;
		case (in_op_q)
			OP_PUSH_START: begin
				if (push_busy) begin
					res_dec.status = STAT_SEQ;
				end else if (too_long || full) begin
					res_dec.status = STAT_FULL;
				end
			end
			OP_PUSH_BYTE: begin
				if (!push_busy) begin
					res_dec.status = STAT_SEQ;
				end else if (push_left_q == len_t'(1)) begin
					res_dec.last_byte = 1'b1;
				end
			end
			OP_POP_BYTE: begin
				if (!pop_open_q && empty) begin
					res_dec.status = STAT_EMPTY;
				end
			end
			default: res_dec.status = STAT_SEQ;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				case (in_op_q)
					OP_PUSH_START: begin
						if (push_busy || too_long || full) begin
							state_d = S_RESP;
						end else if (need_mark) begin
							state_d = S_MARK_LO;
						end else begin
							state_d = S_HDR_LO;
						end
					end
					OP_POP_BYTE: begin
						if (pop_open_q) begin
							state_d = S_RD_DATA;
						end else if (empty) begin
							state_d = S_RESP;
						end else begin
							state_d = S_RD_HHI;
						end
					end
					default: state_d = S_RESP;
				endcase
			end
			S_MARK_LO: state_d = S_MARK_HI;
			S_MARK_HI: state_d = S_HDR_LO;
			S_HDR_LO:  state_d = S_HDR_HI;
			S_HDR_HI:  state_d = S_RESP;
			S_RD_HHI:  state_d = S_RD_HCHK;
			S_RD_HCHK: begin
				if (hdr == WRAP_MARK) begin
					state_d = S_RD_HHI;
				end else if (hdr == '0) begin
					state_d = S_RESP;
				end else begin
					state_d = S_RD_DATA;
				end
			end
			S_RD_DATA: state_d = S_RESP;
			S_RESP: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// store accesses and handshakes
	always_comb begin
		wr        = '0;
		rd        = '0;
		in_ready  = state_q == S_IDLE;
		res_valid = state_q == S_RESP;
		case (state_q)
			S_DECIDE: begin
				if (in_op_q == OP_PUSH_BYTE && push_busy) begin
					wr = '{en: 1'b1, addr: AW'(wcur_q), data: in_din_q};
				end else if (in_op_q == OP_POP_BYTE) begin
					if (pop_open_q) begin
						rd = '{en: 1'b1, addr: AW'(rcur_q)};
					end else if (!empty) begin
						rd = '{en: 1'b1, addr: AW'(roff_q)};
					end
				end
			end
			S_MARK_LO: wr = '{en: 1'b1, addr: AW'(commit_q), data: 8'hFF};
			S_MARK_HI: wr = '{en: 1'b1, addr: AW'(commit_q + pos_t'(1)), data: 8'hFF};
			S_HDR_LO:  wr = '{en: 1'b1, addr: AW'(dest_q), data: in_len_q[7:0]};
			S_HDR_HI:  wr = '{en: 1'b1, addr: AW'(dest_q + pos_t'(1)), data: in_len_q[15:8]};
			S_RD_HHI:  rd = '{en: 1'b1, addr: AW'(roff_q + pos_t'(1))};
			S_RD_HCHK: begin
				if (hdr == WRAP_MARK) begin
					rd = '{en: 1'b1, addr: '0};
				end else if (hdr != '0) begin
					rd = '{en: 1'b1, addr: AW'(roff_q + pos_t'(HDR_BYTES))};
				end
			end
			default: begin
				wr = '0;
				rd = '0;
			end
		endcase
	end

	assign res = res_q;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			commit_q    <= '0;
			wcur_q      <= '0;
			roff_q      <= LAST_HDR_POS;
			rcur_q      <= '0;
			never_q     <= 1'b1;
			push_left_q <= '0;
			pop_left_q  <= '0;
			pop_open_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_DECIDE: begin
					if (in_op_q == OP_PUSH_BYTE && push_busy) begin
						wcur_q      <= wcur_q + pos_t'(1);
						push_left_q <= push_left_q - len_t'(1);
						if (push_left_q == len_t'(1)) begin
							commit_q <= settle(wcur_q + pos_t'(1));
							never_q  <= 1'b0;
						end
					end
				end
				S_HDR_HI: begin
					wcur_q      <= dest_q + pos_t'(HDR_BYTES);
					push_left_q <= in_len_q;
					if (in_len_q == '0) begin
						commit_q <= settle(dest_q + pos_t'(HDR_BYTES));
						never_q  <= 1'b0;
					end
				end
				S_RD_HCHK: begin
					if (hdr == WRAP_MARK) begin
						roff_q <= '0;
					end else begin
						pop_left_q <= hdr;
						rcur_q     <= roff_q + pos_t'(HDR_BYTES);
						if (hdr == '0) begin
							roff_q <= settle(roff_q + pos_t'(HDR_BYTES));
						end else begin
							pop_open_q <= 1'b1;
						end
					end
				end
				S_RD_DATA: begin
					rcur_q     <= rcur_q + pos_t'(1);
					pop_left_q <= pop_left_q - len_t'(1);
					if (pop_left_q == len_t'(1)) begin
						roff_q     <= settle(rcur_q + pos_t'(1));
						pop_open_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// word and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					in_op_q  <= in_op;
					in_len_q <= in_len;
					in_din_q <= in_din;
				end
			end
			S_DECIDE: begin
				res_q  <= res_dec;
				dest_q <= dest;
			end
			S_HDR_HI: begin
				if (in_len_q == '0) begin
					res_q.last_byte <= 1'b1;
				end
			end
			S_RD_HHI: hdr_lo_q <= rdata;
			S_RD_HCHK: begin
				plen_q <= hdr;
				if (hdr == '0) begin
					res_q.last_byte <= 1'b1;
				end
			end
			S_RD_DATA: begin
				res_q.data_out      <= rdata;
				res_q.popped_length <= plen_q;
				if (pop_left_q == len_t'(1)) begin
					res_q.last_byte <= 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
